// ===== sv/categorical_sampler_with_lcg_defines.svh =====
// assertion macros for the categorical sampler
`ifndef CATEGORICAL_SAMPLER_WITH_LCG_DEFINES_SVH
`define CATEGORICAL_SAMPLER_WITH_LCG_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/csl_pkg.sv =====
// shared types and constants for the categorical sampler
package csl_pkg;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_SEED   = 2'd2;

    localparam logic CFG_NUM_CATEGORIES = 1'b0;
    localparam logic CFG_BASE_INDEX     = 1'b1;

    localparam int CFG_DATA_W = 8;
    localparam int NUM_CAT_W  = 5;
    localparam int BASE_W     = 8;
    localparam int CAT_W      = 9;
    localparam int PROB_W     = 16;
    localparam int SEED_W     = 32;
    localparam int KEY_W      = 30;

    localparam logic [SEED_W-1:0] LCG_MULT = 32'h278D_DE6D;
    localparam logic [NUM_CAT_W-1:0] NUM_CAT_RESET = 5'd16;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SEED_W-1:0] rem;
    } t_token;

endpackage

// ===== sv/csl_in_if.sv =====
// input channel of the categorical sampler
interface csl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  bin_number;
    logic [15:0] probability;
    logic [29:0] seed_key;

    modport source (output valid, output mode, output bin_number, output probability,
                    output seed_key, input ready);
    modport sink (input valid, input mode, input bin_number, input probability,
                  input seed_key, output ready);
endinterface

// ===== sv/csl_out_if.sv =====
// result channel of the categorical sampler
interface csl_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  category;
    logic [31:0] uniform_value;
    logic        overrun;

    modport source (output valid, output category, output uniform_value, output overrun,
                    input ready);
    modport sink (input valid, input category, input uniform_value, input overrun,
                  output ready);
endinterface

// ===== sv/categorical_sampler_with_lcg.sv =====
// categorical sampler: seed generator, chain of bin cells and result register
//
// Input channel i_in takes one item per transfer. Mode load writes one bin
// probability (Q0.16) and is done at the transfer. Mode seed sets the seed to
// 4k+1 and advances it once; the block is busy until the multiply is done. Mode
// sample advances the seed, then the remainder walks a chain of MAX_CATEGORIES
// cells, one cell per cycle, and the result is registered on o_out. One sample
// is in flight at a time: the next item is taken only after the result
// transfer, so the length of the cell chain sets the time per sample. Mode
// three is taken and ignored.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) is to be written by the
// user while idle; the block itself does not enforce this.
// Index 0 is the number of bins in use, index 1 the base label.
// Synchronous active-low reset sets the seed to one, 16 bins in use and base
// zero; table entries are undefined until loaded. While the receiver stalls,
// the result holds on o_out and no new item is taken.
`include "categorical_sampler_with_lcg_defines.svh"

module categorical_sampler_with_lcg #(
    parameter int MAX_CATEGORIES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [csl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    csl_in_if.sink                           i_in,
    csl_out_if.source                        o_out
);
    import csl_pkg::*;

    localparam int IW = $clog2(MAX_CATEGORIES);
    localparam int CW = ($clog2(MAX_CATEGORIES + 1) > NUM_CAT_W) ?
                        $clog2(MAX_CATEGORIES + 1) : NUM_CAT_W;

    logic [NUM_CAT_W-1:0] r_num_cat;
    logic [BASE_W-1:0]    r_base;
    logic [SEED_W-1:0]    r_seed;
    logic [SEED_W-1:0]    r_mul_in;
    logic                 r_mul_go;
    logic                 r_mul_smp;
    logic                 r_launch;
    logic                 r_busy;
    logic                 r_out_valid;
    logic [CAT_W-1:0]     r_cat;
    logic                 r_over;

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic [CW-1:0]        w_num_ext;
    logic [IW-1:0]        w_last;
    logic [IW-1:0]        w_final_idx;
    logic [MAX_CATEGORIES-1:0] w_tok_vld;
    logic [MAX_CATEGORIES-1:0] w_we;

    t_token               w_tok    [0:MAX_CATEGORIES];
    logic [IW-1:0]        w_chosen [0:MAX_CATEGORIES];

    assign i_in.ready = !r_busy;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = r_out_valid && o_out.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cat <= NUM_CAT_RESET;
            r_base    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_CATEGORIES: r_num_cat <= i_cfg_data[NUM_CAT_W-1:0];
                CFG_BASE_INDEX:     r_base    <= i_cfg_data[BASE_W-1:0];
                default:            r_base    <= r_base;
            endcase
        end
    end

    // last bin in use, clamped to the table
    assign w_num_ext = CW'(r_num_cat);
    always_comb begin
        if (w_num_ext == '0) begin
            w_last = '0;
        end else if (w_num_ext > CW'(MAX_CATEGORIES)) begin
            w_last = IW'(MAX_CATEGORIES - 1);
        end else begin
            w_last = IW'(w_num_ext - CW'(1));
        end
    end

    // seed generator: operand register, then multiply into the seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_go  <= 1'b0;
            r_mul_smp <= 1'b0;
            r_launch  <= 1'b0;
            r_seed    <= SEED_W'(1);
        end else begin
            r_mul_go  <= w_in_acc && ((i_in.mode == MODE_SAMPLE) || (i_in.mode == MODE_SEED));
            r_mul_smp <= w_in_acc && (i_in.mode == MODE_SAMPLE);
            r_launch  <= r_mul_go && r_mul_smp;
            if (r_mul_go) begin
                r_seed <= r_mul_in * LCG_MULT;
            end
        end
        if (w_in_acc) begin
            r_mul_in <= (i_in.mode == MODE_SEED) ? {i_in.seed_key, 2'b01} : r_seed;
        end
    end

    // busy from a seed or sample transfer until its work is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_acc &&
                     ((i_in.mode == MODE_SAMPLE) || (i_in.mode == MODE_SEED))) begin
            r_busy <= 1'b1;
        end else if ((r_mul_go && !r_mul_smp) || w_out_acc) begin
            r_busy <= 1'b0;
        end
    end

    assign w_tok[0].valid = r_launch;
    assign w_tok[0].found = 1'b0;
    assign w_tok[0].rem   = r_seed;
    assign w_chosen[0]    = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_CATEGORIES; g++) begin : g_cell
            assign w_we[g] = w_in_acc && (i_in.mode == MODE_LOAD) &&
                             (32'(i_in.bin_number) == g);

            csl_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_we     (w_we[g]),
                .i_prob   (i_in.probability),
                .i_last   (w_last),
                .i_tok    (w_tok[g]),
                .i_chosen (w_chosen[g]),
                .o_tok    (w_tok[g+1]),
                .o_chosen (w_chosen[g+1])
            );

            assign w_tok_vld[g] = w_tok[g+1].valid;
        end
    endgenerate

    // result register
    assign w_final_idx = w_tok[MAX_CATEGORIES].found ? w_chosen[MAX_CATEGORIES] : w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tok[MAX_CATEGORIES].valid) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
        if (w_tok[MAX_CATEGORIES].valid) begin
            r_cat  <= CAT_W'(w_final_idx) + CAT_W'(r_base);
            r_over <= !w_tok[MAX_CATEGORIES].found;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.category      = r_cat;
    assign o_out.uniform_value = r_seed;
    assign o_out.overrun       = r_over;

    `CSL_ASSERT_NOW(a_one_token, i_clk, i_rst_n, 1'b1, $countones(w_tok_vld) <= 1, "more than one token in the chain")
    `CSL_ASSERT_NOW(a_no_take_while_result, i_clk, i_rst_n, r_out_valid, !i_in.ready, "input taken while a result waits")
    `CSL_ASSERT_NOW(a_no_exit_over_result, i_clk, i_rst_n, w_tok[MAX_CATEGORIES].valid, !r_out_valid, "token left chain over a pending result")
    `CSL_ASSERT_NEXT(a_seed_busy, i_clk, i_rst_n, w_in_acc && (i_in.mode == MODE_SEED), !i_in.ready && r_mul_go, "seed transfer did not start the multiply")

endmodule

// ===== sv/csl_cell.sv =====
// one bin of the walk chain: holds a probability and compares/subtracts the remainder
module csl_cell #(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [csl_pkg::PROB_W-1:0]  i_prob,
    input  logic [IW-1:0]               i_last,
    input  csl_pkg::t_token             i_tok,
    input  logic [IW-1:0]               i_chosen,
    output csl_pkg::t_token             o_tok,
    output logic [IW-1:0]               o_chosen
);
    import csl_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [PROB_W-1:0] r_prob;
    t_token            r_tok;
    t_token            n_tok;
    logic [IW-1:0]     r_chosen;
    logic [IW-1:0]     n_chosen;
    logic [SEED_W-1:0] w_p;
    logic              w_active;

    assign w_p      = {r_prob, {(SEED_W-PROB_W){1'b0}}};
    assign w_active = i_tok.valid && !i_tok.found && (MY_IDX <= i_last);

    always_comb begin
        n_tok    = i_tok;
        n_chosen = i_chosen;
        if (w_active) begin
            if (i_tok.rem < w_p) begin
                n_tok.found = 1'b1;
                n_chosen    = MY_IDX;
            end else begin
                n_tok.rem = i_tok.rem - w_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_prob <= i_prob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.rem   <= n_tok.rem;
        r_chosen    <= n_chosen;
    end

    assign o_tok    = r_tok;
    assign o_chosen = r_chosen;

endmodule

// ===== test/tb_categorical_sampler_with_lcg.sv =====
// self-checking testbench for the categorical sampler: directed and random draws
module tb_categorical_sampler_with_lcg;
    import csl_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int         TABLE_DEPTH  = 16;
    localparam int         DRAIN_CYCLES = TABLE_DEPTH + 4;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         PHASES       = 12;
    localparam int         PHASE_ITEMS  = 70;

    typedef struct packed {
        logic [CAT_W-1:0]  category;
        logic [SEED_W-1:0] uniform;
        logic              overrun;
    } t_draw;

    class category_predictor;
        logic [SEED_W-1:0]    seed;
        logic [PROB_W-1:0]    prob_table [TABLE_DEPTH];
        logic [NUM_CAT_W-1:0] num_cat;
        logic [BASE_W-1:0]    base;
        t_draw                pending_draws [$];
        int                   mismatches;
        int                   draws, overruns, deepest, loads, seeds, ignored;

        function new();
            seed       = SEED_W'(1);
            num_cat    = NUM_CAT_RESET;
            base       = '0;
            mismatches = 0;
            draws      = 0;
            overruns   = 0;
            deepest    = 0;
            loads      = 0;
            seeds      = 0;
            ignored    = 0;
            foreach (prob_table[b]) prob_table[b] = '0;
        endfunction

        function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NUM_CATEGORIES) num_cat = data[NUM_CAT_W-1:0];
            else base = data[BASE_W-1:0];
        endfunction

        function void note_transfer(logic [1:0] mode, logic [3:0] bin,
                                    logic [PROB_W-1:0] prob, logic [KEY_W-1:0] key);
            logic [SEED_W-1:0] rest;
            logic [SEED_W-1:0] weight;
            int                n;
            int                pick;
            logic              found;
            t_draw             d;
            case (mode)
                MODE_LOAD: begin
                    prob_table[bin] = prob;
                    loads++;
                end
                MODE_SEED: begin
                    seed = {key, 2'b01} * LCG_MULT;
                    seeds++;
                end
                MODE_SAMPLE: begin
                    seed = seed * LCG_MULT;
                    rest = seed;
                    n = (num_cat == 0) ? 1 :
                        (int'(num_cat) > TABLE_DEPTH) ? TABLE_DEPTH : int'(num_cat);
                    pick = n - 1;
                    found = 1'b0;
                    for (int b = 0; b < n; b++) begin
                        weight = {prob_table[b], 16'h0000};
                        if (!found) begin
                            if (rest < weight) begin
                                pick = b;
                                found = 1'b1;
                            end else begin
                                rest = rest - weight;
                            end
                        end
                    end
                    d.category = CAT_W'(pick + int'(base));
                    d.uniform = seed;
                    d.overrun = !found;
                    pending_draws.push_back(d);
                    draws++;
                    if (!found) overruns++;
                    if (found && pick > deepest) deepest = pick;
                end
                default: ignored++;
            endcase
        endfunction

        function void check_draw(logic [CAT_W-1:0] category, logic [SEED_W-1:0] uniform,
                                 logic overrun);
            t_draw d;
            if (pending_draws.size() == 0) begin
                $display("%0t: result with no draw pending: category %0d uniform %h",
                         $time, category, uniform);
                mismatches++;
            end else begin
                d = pending_draws.pop_front();
                if (category !== d.category) begin
                    $display("%0t: category expected %0d actual %0d",
                             $time, d.category, category);
                    mismatches++;
                end
                if (uniform !== d.uniform) begin
                    $display("%0t: uniform_value expected %h actual %h",
                             $time, d.uniform, uniform);
                    mismatches++;
                end
                if (overrun !== d.overrun) begin
                    $display("%0t: overrun expected %0d actual %0d",
                             $time, d.overrun, overrun);
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return pending_draws.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    csl_in_if  in_ch ();
    csl_out_if out_ch ();

    categorical_sampler_with_lcg uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    category_predictor predictor = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int settings      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d draws pending", cycle_count,
                     predictor.outstanding());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // transfers seen at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                predictor.check_draw(out_ch.category, out_ch.uniform_value, out_ch.overrun);
            if (in_ch.valid && in_ch.ready)
                predictor.note_transfer(in_ch.mode, in_ch.bin_number, in_ch.probability,
                                        in_ch.seed_key);
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [3:0] bin,
                             input logic [PROB_W-1:0] prob, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.mode        = mode;
        in_ch.bin_number  = bin;
        in_ch.probability = prob;
        in_ch.seed_key    = key;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (predictor.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        predictor.write_reg(idx, data);
    endtask

    task automatic load_table(input int style);
        logic [PROB_W-1:0] prob;
        for (int b = 0; b < TABLE_DEPTH; b++) begin
            case (style)
                0: prob = PROB_W'($urandom_range(0, 8192));
                1: prob = PROB_W'($urandom_range(0, 2000));
                2: prob = PROB_W'($urandom);
                default: prob = ($urandom_range(0, 3) == 0) ? PROB_W'($urandom) : 16'h0000;
            endcase
            send_item(MODE_LOAD, 4'(b), prob, KEY_W'($urandom));
        end
    endtask

    task automatic random_item();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            send_item(MODE_SAMPLE, 4'($urandom), PROB_W'($urandom), KEY_W'($urandom));
        else if (roll < 80)
            send_item(MODE_SEED, 4'($urandom), PROB_W'($urandom), KEY_W'($urandom));
        else if (roll < 92)
            send_item(MODE_LOAD, 4'($urandom), PROB_W'($urandom), KEY_W'($urandom));
        else
            send_item(MODE_IGNORED, 4'($urandom), PROB_W'($urandom), KEY_W'($urandom));
    endtask

    initial begin
        int                    num_list [PHASES];
        int                    base_list [PHASES];
        logic [CFG_DATA_W-1:0] data;
        num_list  = '{0, 16, 1, 31, 7, 17, 2, 16, 12, 4, 9, 16};
        base_list = '{0, 255, 128, 3, 255, 0, 77, 200, 1, 254, 64, 15};

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_NUM_CATEGORIES;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_LOAD;
        in_ch.bin_number  = '0;
        in_ch.probability = '0;
        in_ch.seed_key    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // every entry loaded before the first draw
        send_item(MODE_LOAD, 4'd0, 16'h0000, '0);
        send_item(MODE_LOAD, 4'd1, 16'h0001, '0);
        send_item(MODE_LOAD, 4'd2, 16'h8000, '0);
        for (int b = 3; b < TABLE_DEPTH - 1; b++)
            send_item(MODE_LOAD, 4'(b), 16'h0800, '0);
        send_item(MODE_LOAD, 4'd15, 16'hFFFF, '0);
        send_item(MODE_SAMPLE, '0, '0, '0);
        send_item(MODE_SEED, '0, '0, 30'd0);
        send_item(MODE_SAMPLE, '0, '0, '0);
        send_item(MODE_SEED, '0, '0, 30'h3FFF_FFFF);
        send_item(MODE_SAMPLE, '0, '0, '0);
        send_item(MODE_IGNORED, 4'hF, 16'hFFFF, 30'h3FFF_FFFF);
        send_item(MODE_SAMPLE, '0, '0, '0);
        send_item(MODE_SEED, '0, '0, KEY_W'($urandom));
        send_item(MODE_SAMPLE, '0, '0, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 37 : (ph < 8) ? 57 : 0;
            recv_idle_pct = (ph < 4) ? 57 : (ph < 8) ? 37 : 0;
            wait_drained();
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            data = CFG_DATA_W'($urandom);
            data[NUM_CAT_W-1:0] = NUM_CAT_W'(num_list[ph]);
            write_reg(CFG_NUM_CATEGORIES, data);
            write_reg(CFG_BASE_INDEX, CFG_DATA_W'(base_list[ph]));
            settings++;
            load_table(ph % 4);
            // long receiver stall while the sender keeps offering
            if (ph == 1) hold_left = 400;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 5 && k == 35) wait_drained();
                random_item();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("draws %0d (overruns %0d, deepest bin chosen %0d), loads %0d, seeds %0d, ignored %0d",
                 predictor.draws, predictor.overruns, predictor.deepest, predictor.loads,
                 predictor.seeds, predictor.ignored);
        $display("%0d register settings incl. zero and oversized bin counts, base labels 0 to 255",
                 settings);
        if (predictor.mismatches == 0 && predictor.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d draws left", predictor.mismatches,
                     predictor.outstanding());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/csl_pkg.sv
sv/csl_in_if.sv
sv/csl_out_if.sv
sv/csl_cell.sv
sv/categorical_sampler_with_lcg.sv
test/tb_categorical_sampler_with_lcg.sv
